### rtl/schsde_pkg.sv
package schsde_pkg;

  localparam int MAX_ATOMS = 32;
  localparam int ADDR_W    = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
  localparam int CNT_W     = $clog2(MAX_ATOMS + 1);
  localparam int SUM_W     = 33 + CNT_W;
  localparam int DATA_W    = 32;
  localparam int OPA_W     = 33;
  localparam int PROD_W    = 65;
  localparam int WIDE_W    = 68;
  localparam int IDX_W     = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DT_W      = 17;
  localparam int RATE_W    = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAVITY_DECAY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEPHASING    = 2'd2;

  localparam logic [DT_W-1:0]   DT_RESET    = 17'd66;
  localparam logic [RATE_W-1:0] KAPPA_RESET = 31'd65536;
  localparam logic [RATE_W-1:0] DEPH_RESET  = 31'd0;

  typedef logic signed [DATA_W-1:0] q16_t;

  // Clamp a wide signed value to the signed 32-bit range.
  function automatic q16_t sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(64'sd2147483647);
    lo = -WIDE_W'(64'sd2147483648);
    if (v > hi) begin
      return q16_t'(hi);
    end else if (v < lo) begin
      return q16_t'(lo);
    end
    return v[DATA_W-1:0];
  endfunction

  // Q16.16 product with rounding and saturation.
  function automatic q16_t mul_round(input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(p) + WIDE_W'(32768);
    return sat32(t >>> 16);
  endfunction

  // Corrector scaling: the product carries the sum of two drifts, so one more
  // bit is dropped to take the mean.
  function automatic q16_t corr_round(input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(p) + WIDE_W'(65536);
    return sat32(t >>> 17);
  endfunction

  function automatic logic signed [OPA_W-1:0] sx33(input q16_t v);
    return {v[DATA_W-1], v};
  endfunction

endpackage

### rtl/schsde_if.sv
interface schsde_in_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic signed [31:0] spin_x;
  logic signed [31:0] spin_y;
  logic signed [31:0] spin_z;
  logic signed [31:0] coupling;
  logic signed [31:0] noise_x;
  logic signed [31:0] noise_y;
  logic signed [31:0] field_q;
  logic signed [31:0] field_p;
  logic signed [31:0] noise_q;
  logic signed [31:0] noise_p;
  modport source (output valid, mode, spin_x, spin_y, spin_z, coupling, noise_x, noise_y,
                  field_q, field_p, noise_q, noise_p, input ready);
  modport sink (input valid, mode, spin_x, spin_y, spin_z, coupling, noise_x, noise_y,
                field_q, field_p, noise_q, noise_p, output ready);
endinterface

interface schsde_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [5:0]  atom_index;
  logic signed [31:0] new_spin_x;
  logic signed [31:0] new_spin_y;
  logic signed [31:0] new_spin_z;
  logic signed [31:0] new_field_q;
  logic signed [31:0] new_field_p;
  logic        overflow;
  logic        last;
  modport source (output valid, kind, atom_index, new_spin_x, new_spin_y, new_spin_z,
                  new_field_q, new_field_p, overflow, last, input ready);
  modport sink (input valid, kind, atom_index, new_spin_x, new_spin_y, new_spin_z,
                new_field_q, new_field_p, overflow, last, output ready);
endinterface

interface schsde_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/schsde_ram.sv
module schsde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

### rtl/schsde_mul.sv
module schsde_mul import schsde_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic signed [OPA_W-1:0]  a_i,
  input  q16_t                     b_i,
  output q16_t                     mq_o,
  output q16_t                     cr_o
);

  logic signed [PROD_W-1:0] prod_q;

  // The product holds while no new operation is issued.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PROD_W'(a_i * b_i);
    end
  end

  assign mq_o = mul_round(prod_q);
  assign cr_o = corr_round(prod_q);

endmodule

### rtl/spin_cavity_heun_sde_step_core.sv
// Heun stochastic step for spins coupled to one cavity mode, Q16.16.
//
// Input channel: a beat with mode 0 stores one atom record (spin x/y/z,
// coupling, noise x/y); it produces no result. Atoms past MAX_ATOMS are
// dropped and the overflow flag is raised. A beat with mode 1 carries the
// field record and starts the step; no input is taken until the step has
// handed its field result to the output register.
// Output channel: one beat per stored atom in load order, then the field beat
// with last set. Overflow is reported on every beat of the step.
// Config channel: always ready; writes go to time step, cavity decay and
// dephasing rate by index, other indexes are ignored. Write only while idle.
// Datapath: all arithmetic runs through a single registered multiplier. A
// step runs pass one over the atoms, the field predictor, pass two over the
// atoms and the field corrector. Atom data and pass-one drifts sit in two
// RAMs with registered reads.
// Reset clears the atom count, the overflow flag, the state and the output
// valid; the RAMs are not cleared, only loaded entries are read. If the
// receiver stalls, the finished beat waits in the output register and the
// sequencer halts before producing the next one.
module spin_cavity_heun_sde_step_core import schsde_pkg::*; (
  input logic           clk_i,
  input logic           rst_ni,
  schsde_in_if.sink     in_i,
  schsde_out_if.source  out_o,
  schsde_cfg_if.sink    cfg_i
);

  typedef enum logic [2:0] {ST_IDLE, ST_P1, ST_F1, ST_P2, ST_F2} state_e;

  state_e            state_q;
  logic [4:0]        step_q;
  logic [ADDR_W-1:0] idx_q;
  logic [CNT_W-1:0]  count_q;
  logic              ovf_q;
  logic [DT_W-1:0]   dt_q;
  logic [RATE_W-1:0] kappa_q;
  logic [RATE_W-1:0] rate_q;

  logic              out_valid_q;
  logic              out_kind_q;
  logic [IDX_W-1:0]  out_idx_q;
  q16_t              out_x_q, out_y_q, out_z_q, out_fq_q, out_fp_q;
  logic              out_ovf_q;
  logic              out_last_q;

  // Datapath registers.
  q16_t              q_q, p_q, nq_q, np_q;
  q16_t              a_q, b_q, dx_q, dy_q, dz_q;
  q16_t              x1_q, y1_q, z1_q, dq_q, dp_q, q1_q, p1_q, ox_q, oy_q;
  logic signed [SUM_W-1:0] jx_q, jy_q;

  logic in_acc, out_free, is_last_atom, emit_atom, emit_field;
  logic atom_we, drift_we;
  logic [191:0] atom_rd;
  logic [95:0]  drift_rd;
  q16_t rx, ry, rz, rg, rnx, rny, rdx, rdy, rdz;
  q16_t cx, cy, cz, cq, cp;
  q16_t kap_b, rate_b, dt_b;
  q16_t mq, cr;
  logic mul_en;
  logic signed [OPA_W-1:0] op_a;
  q16_t op_b;
  logic [4:0] ds;
  logic drift_issue, drift_wb;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;
  assign is_last_atom = (idx_q == ADDR_W'(count_q - CNT_W'(1)));
  assign emit_atom   = (state_q == ST_P2) && (step_q == 5'd18) && out_free;
  assign emit_field  = (state_q == ST_F2) && (step_q == 5'd5) && out_free;

  assign atom_we  = in_acc && !in_i.mode && (count_q < CNT_W'(MAX_ATOMS));
  assign drift_we = (state_q == ST_P1) && (step_q == 5'd11);

  schsde_ram #(.WIDTH(192), .DEPTH(MAX_ATOMS)) u_atom_ram (
    .clk_i   (clk_i),
    .we_i    (atom_we),
    .waddr_i (count_q[ADDR_W-1:0]),
    .wdata_i ({in_i.noise_y, in_i.noise_x, in_i.coupling,
               in_i.spin_z, in_i.spin_y, in_i.spin_x}),
    .raddr_i (idx_q),
    .rdata_o (atom_rd)
  );

  schsde_ram #(.WIDTH(96), .DEPTH(MAX_ATOMS)) u_drift_ram (
    .clk_i   (clk_i),
    .we_i    (drift_we),
    .waddr_i (idx_q),
    .wdata_i ({q16_t'(mq >>> 1), dy_q, dx_q}),
    .raddr_i (idx_q),
    .rdata_o (drift_rd)
  );

  assign rx  = atom_rd[31:0];
  assign ry  = atom_rd[63:32];
  assign rz  = atom_rd[95:64];
  assign rg  = atom_rd[127:96];
  assign rnx = atom_rd[159:128];
  assign rny = atom_rd[191:160];
  assign rdx = drift_rd[31:0];
  assign rdy = drift_rd[63:32];
  assign rdz = drift_rd[95:64];

  // The drift sequence runs on the stored point in pass one and on the
  // predicted point in pass two.
  assign cx = (state_q == ST_P2) ? x1_q : rx;
  assign cy = (state_q == ST_P2) ? y1_q : ry;
  assign cz = (state_q == ST_P2) ? z1_q : rz;
  assign cq = (state_q == ST_P2) ? q1_q : q_q;
  assign cp = (state_q == ST_P2) ? p1_q : p_q;

  assign kap_b  = {1'b0, kappa_q};
  assign rate_b = {1'b0, rate_q};
  assign dt_b   = {{(DATA_W - DT_W){1'b0}}, dt_q};

  assign ds = (state_q == ST_P2) ? (step_q - 5'd3) : step_q;
  assign drift_issue = ((state_q == ST_P1) && (step_q >= 5'd1) && (step_q <= 5'd11)) ||
                       ((state_q == ST_P2) && (step_q >= 5'd4) && (step_q <= 5'd14));
  assign drift_wb    = ((state_q == ST_P1) && (step_q >= 5'd2) && (step_q <= 5'd12)) ||
                       ((state_q == ST_P2) && (step_q >= 5'd5) && (step_q <= 5'd15));

  schsde_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (op_a),
    .b_i   (op_b),
    .mq_o  (mq),
    .cr_o  (cr)
  );

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_en = 1'b0;
    op_a   = '0;
    op_b   = '0;
    if (drift_issue) begin
      mul_en = 1'b1;
      case (ds)
        5'd1:    begin op_a = sx33(rg);  op_b = cp;     end
        5'd2:    begin op_a = sx33(cx);  op_b = rate_b; end
        5'd3:    begin op_a = sx33(a_q); op_b = cz;     end
        5'd4:    begin op_a = sx33(rg);  op_b = cq;     end
        5'd5:    begin op_a = sx33(cy);  op_b = rate_b; end
        5'd6:    begin op_a = sx33(a_q); op_b = cz;     end
        5'd7:    begin op_a = sx33(cq);  op_b = cy;     end
        5'd8:    begin op_a = sx33(cp);  op_b = cx;     end
        5'd9:    begin op_a = sx33(cx);  op_b = rg;     end
        5'd10:   begin op_a = sx33(rg);  op_b = a_q;    end
        5'd11:   begin op_a = sx33(cy);  op_b = rg;     end
        default: begin op_a = '0;        op_b = '0;     end
      endcase
    end else if (state_q == ST_P2) begin
      mul_en = 1'b1;
      op_b   = dt_b;
      case (step_q)
        5'd1:    op_a = sx33(rdx);
        5'd2:    op_a = sx33(rdy);
        5'd3:    op_a = sx33(rdz);
        5'd15:   op_a = sx33(rdx) + sx33(dx_q);
        5'd16:   op_a = sx33(rdy) + sx33(dy_q);
        5'd17:   op_a = sx33(rdz) + sx33(dz_q);
        default: mul_en = 1'b0;
      endcase
    end else if (state_q == ST_F1) begin
      mul_en = 1'b1;
      case (step_q)
        5'd1:    begin op_a = sx33(q_q);  op_b = kap_b; end
        5'd2:    begin op_a = sx33(p_q);  op_b = kap_b; end
        5'd3:    begin op_a = sx33(dq_q); op_b = dt_b;  end
        5'd4:    begin op_a = sx33(dp_q); op_b = dt_b;  end
        default: mul_en = 1'b0;
      endcase
    end else if (state_q == ST_F2) begin
      mul_en = 1'b1;
      case (step_q)
        5'd1:    begin op_a = sx33(q1_q); op_b = kap_b; end
        5'd2:    begin op_a = sx33(p1_q); op_b = kap_b; end
        5'd3:    begin op_a = sx33(dq_q) + sx33(a_q); op_b = dt_b; end
        5'd4:    begin op_a = sx33(dp_q) + sx33(b_q); op_b = dt_b; end
        default: mul_en = 1'b0;
      endcase
    end
  end

  // Datapath updates, keyed on the same schedule in the cycle after each issue.
  always_ff @(posedge clk_i) begin
    if (in_acc && in_i.mode) begin
      q_q  <= in_i.field_q;
      p_q  <= in_i.field_p;
      nq_q <= in_i.noise_q;
      np_q <= in_i.noise_p;
      jx_q <= '0;
      jy_q <= '0;
    end
    if (drift_wb) begin
      case (ds)
        5'd2:  a_q  <= mq;
        5'd3:  b_q  <= mq;
        5'd4:  dx_q <= sat32(WIDE_W'(mq >>> 1) - WIDE_W'(b_q));
        5'd5:  a_q  <= mq;
        5'd6:  b_q  <= mq;
        5'd7:  dy_q <= sat32(-WIDE_W'(mq >>> 1) - WIDE_W'(b_q));
        5'd8:  a_q  <= mq;
        5'd9:  a_q  <= sat32(WIDE_W'(a_q) - WIDE_W'(mq));
        5'd10: jx_q <= jx_q + SUM_W'(mq);
        5'd11: dz_q <= mq >>> 1;
        5'd12: jy_q <= jy_q + SUM_W'(mq);
        default: ;
      endcase
    end
    if (state_q == ST_P2) begin
      case (step_q)
        5'd2:  x1_q <= sat32(WIDE_W'(rx) + WIDE_W'(mq) + WIDE_W'(rnx));
        5'd3:  y1_q <= sat32(WIDE_W'(ry) + WIDE_W'(mq) + WIDE_W'(rny));
        5'd4:  z1_q <= sat32(WIDE_W'(rz) + WIDE_W'(mq));
        5'd16: ox_q <= sat32(WIDE_W'(rx) + WIDE_W'(cr) + WIDE_W'(rnx));
        5'd17: oy_q <= sat32(WIDE_W'(ry) + WIDE_W'(cr) + WIDE_W'(rny));
        default: ;
      endcase
    end
    if (state_q == ST_F1) begin
      case (step_q)
        5'd2: dq_q <= sat32(-WIDE_W'(jy_q >>> 1) - WIDE_W'(mq >>> 1));
        5'd3: dp_q <= sat32(WIDE_W'(jx_q >>> 1) - WIDE_W'(mq >>> 1));
        5'd4: q1_q <= sat32(WIDE_W'(q_q) + WIDE_W'(mq) + WIDE_W'(nq_q));
        5'd5: begin
          p1_q <= sat32(WIDE_W'(p_q) + WIDE_W'(mq) + WIDE_W'(np_q));
          jx_q <= '0;
          jy_q <= '0;
        end
        default: ;
      endcase
    end
    if (state_q == ST_F2) begin
      case (step_q)
        5'd2: a_q  <= sat32(-WIDE_W'(jy_q >>> 1) - WIDE_W'(mq >>> 1));
        5'd3: b_q  <= sat32(WIDE_W'(jx_q >>> 1) - WIDE_W'(mq >>> 1));
        5'd4: ox_q <= sat32(WIDE_W'(q_q) + WIDE_W'(cr) + WIDE_W'(nq_q));
        default: ;
      endcase
    end
  end

  // Sequencer, configuration registers and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      idx_q       <= '0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      dt_q        <= DT_RESET;
      kappa_q     <= KAPPA_RESET;
      rate_q      <= DEPH_RESET;
      out_valid_q <= 1'b0;
      out_kind_q  <= 1'b0;
      out_idx_q   <= '0;
      out_x_q     <= '0;
      out_y_q     <= '0;
      out_z_q     <= '0;
      out_fq_q    <= '0;
      out_fp_q    <= '0;
      out_ovf_q   <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        case (cfg_i.index)
          CFG_TIME_STEP:    dt_q    <= cfg_i.data[DT_W-1:0];
          CFG_CAVITY_DECAY: kappa_q <= cfg_i.data[RATE_W-1:0];
          CFG_DEPHASING:    rate_q  <= cfg_i.data[RATE_W-1:0];
          default: ;
        endcase
      end

      if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (!in_i.mode) begin
              if (count_q < CNT_W'(MAX_ATOMS)) begin
                count_q <= count_q + CNT_W'(1);
              end else begin
                ovf_q <= 1'b1;
              end
            end else begin
              idx_q <= '0;
              if (count_q == '0) begin
                state_q <= ST_F1;
                step_q  <= 5'd1;
              end else begin
                state_q <= ST_P1;
                step_q  <= 5'd0;
              end
            end
          end
        end
        ST_P1: begin
          if (step_q == 5'd12) begin
            step_q <= 5'd0;
            if (is_last_atom) begin
              state_q <= ST_F1;
              step_q  <= 5'd1;
            end else begin
              idx_q <= idx_q + ADDR_W'(1);
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_F1: begin
          if (step_q == 5'd5) begin
            idx_q <= '0;
            if (count_q == '0) begin
              state_q <= ST_F2;
              step_q  <= 5'd1;
            end else begin
              state_q <= ST_P2;
              step_q  <= 5'd0;
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_P2: begin
          if (step_q == 5'd18) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= 1'b0;
              out_idx_q   <= IDX_W'(idx_q);
              out_x_q     <= ox_q;
              out_y_q     <= oy_q;
              out_z_q     <= sat32(WIDE_W'(rz) + WIDE_W'(cr));
              out_fq_q    <= '0;
              out_fp_q    <= '0;
              out_ovf_q   <= ovf_q;
              out_last_q  <= 1'b0;
              step_q      <= 5'd0;
              if (is_last_atom) begin
                state_q <= ST_F2;
                step_q  <= 5'd1;
              end else begin
                idx_q <= idx_q + ADDR_W'(1);
              end
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        ST_F2: begin
          if (step_q == 5'd5) begin
            if (out_free) begin
              out_valid_q <= 1'b1;
              out_kind_q  <= 1'b1;
              out_idx_q   <= '0;
              out_x_q     <= '0;
              out_y_q     <= '0;
              out_z_q     <= '0;
              out_fq_q    <= ox_q;
              out_fp_q    <= sat32(WIDE_W'(p_q) + WIDE_W'(cr) + WIDE_W'(np_q));
              out_ovf_q   <= ovf_q;
              out_last_q  <= 1'b1;
              count_q     <= '0;
              ovf_q       <= 1'b0;
              state_q     <= ST_IDLE;
              step_q      <= '0;
            end
          end else begin
            step_q <= step_q + 5'd1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.kind        = out_kind_q;
  assign out_o.atom_index  = out_idx_q;
  assign out_o.new_spin_x  = out_x_q;
  assign out_o.new_spin_y  = out_y_q;
  assign out_o.new_spin_z  = out_z_q;
  assign out_o.new_field_q = out_fq_q;
  assign out_o.new_field_p = out_fp_q;
  assign out_o.overflow    = out_ovf_q;
  assign out_o.last        = out_last_q;

  // The atom count never passes the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_ATOMS))
    else $error("atom count beyond capacity");

  // Handing over the field beat ends the step and clears the batch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_field |=> (state_q == ST_IDLE) && (count_q == '0) && !ovf_q && out_o.last)
    else $error("step did not close after the field beat");

  // A pending atom beat belongs to the running pass and to a stored atom.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.kind) |->
      ((state_q == ST_P2 || state_q == ST_F2) && (CNT_W'(out_o.atom_index) < count_q)))
    else $error("atom beat outside its pass");

  // No atom is emitted before pass one has finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_P1) |-> !(emit_atom || emit_field))
    else $error("result produced during pass one");

endmodule

### tb/spin_cavity_heun_sde_step_core_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the Heun step core. Atom beats are stored by a
// behavioral copy of the block; each field beat runs the full two-pass step
// in that copy, and the expected atom and field beats are queued in order.
// A negedge monitor compares every output beat field by field.
module spin_cavity_heun_sde_step_core_tb;
  import schsde_pkg::*;

  // One input beat as the sender sees it.
  typedef struct {
    logic        mode;
    logic [31:0] sx, sy, sz, g, nx, ny, fq, fp, nq, np;
  } beat_t;

  // One expected output beat.
  typedef struct {
    logic        kind;
    logic [5:0]  idx;
    logic [31:0] x, y, z, q, p;
    logic        ovf;
    logic        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  schsde_in_if  in_if ();
  schsde_out_if out_if ();
  schsde_cfg_if cfg_if ();

  spin_cavity_heun_sde_step_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #5 clk = ~clk;

  // Shadow copy of the block: configuration, atom stores and batch state.
  longint unsigned dt_q, kappa_q, deph_q;
  longint atom_x [MAX_ATOMS];
  longint atom_y [MAX_ATOMS];
  longint atom_z [MAX_ATOMS];
  longint atom_g [MAX_ATOMS];
  longint atom_nx [MAX_ATOMS];
  longint atom_ny [MAX_ATOMS];
  int     n_atoms;
  logic   dropped;

  result_t pending_results[$];
  int      mismatches;
  bit      quiet;        // when set, both sides run back to back
  int      hold_cycles;  // long receiver hold-off requested by a test
  bit      beat_taken;   // set by the monitor when an output beat is accepted

  // Fixed-point helpers, all on 64-bit signed values.
  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return clamp32((a * b + 64'sd32768) >>> 16);
  endfunction

  function automatic longint sext(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // Drift of one spin at the given field point.
  task automatic spin_drift(input longint x, y, z, g, q, p,
                            output longint dx, dy, dz);
    longint r;
    r = longint'(deph_q);
    dx = clamp32((qmul(qmul(g, p), z) >>> 1) - qmul(r, x));
    dy = clamp32(-(qmul(qmul(g, q), z) >>> 1) - qmul(r, y));
    dz = qmul(g, clamp32(qmul(q, y) - qmul(p, x))) >>> 1;
  endtask

  function automatic longint euler_guess(longint v, longint d, longint n);
    return clamp32(v + qmul(d, longint'(dt_q)) + n);
  endfunction

  function automatic longint heun_fix(longint v, longint d0, longint d1, longint n);
    longint c;
    c = clamp32(((d0 + d1) * longint'(dt_q) + 64'sd65536) >>> 17);
    return clamp32(v + c + n);
  endfunction

  // Applies one accepted input beat to the shadow copy. A field beat runs the
  // whole step and queues every beat it should produce.
  task automatic absorb_beat(input beat_t b);
    longint q, p, nq, np, jx, jy, dq, dp, q1, p1, dq2, dp2, k;
    longint x1, y1, z1, ex, ey, ez;
    longint d0 [MAX_ATOMS];
    longint d1 [MAX_ATOMS];
    longint d2 [MAX_ATOMS];
    result_t r;
    if (b.mode == 1'b0) begin
      if (n_atoms >= MAX_ATOMS) begin
        dropped = 1'b1;
      end else begin
        atom_x[n_atoms] = sext(b.sx);
        atom_y[n_atoms] = sext(b.sy);
        atom_z[n_atoms] = sext(b.sz);
        atom_g[n_atoms] = sext(b.g);
        atom_nx[n_atoms] = sext(b.nx);
        atom_ny[n_atoms] = sext(b.ny);
        n_atoms++;
      end
      return;
    end
    q = sext(b.fq);
    p = sext(b.fp);
    nq = sext(b.nq);
    np = sext(b.np);
    k = longint'(kappa_q);
    jx = 0;
    jy = 0;
    for (int i = 0; i < n_atoms; i++) begin
      spin_drift(atom_x[i], atom_y[i], atom_z[i], atom_g[i], q, p, d0[i], d1[i], d2[i]);
      jx += qmul(atom_x[i], atom_g[i]);
      jy += qmul(atom_y[i], atom_g[i]);
    end
    dq = clamp32(-(jy >>> 1) - (qmul(k, q) >>> 1));
    dp = clamp32((jx >>> 1) - (qmul(k, p) >>> 1));
    q1 = euler_guess(q, dq, nq);
    p1 = euler_guess(p, dp, np);
    jx = 0;
    jy = 0;
    for (int i = 0; i < n_atoms; i++) begin
      x1 = euler_guess(atom_x[i], d0[i], atom_nx[i]);
      y1 = euler_guess(atom_y[i], d1[i], atom_ny[i]);
      z1 = euler_guess(atom_z[i], d2[i], 0);
      spin_drift(x1, y1, z1, atom_g[i], q1, p1, ex, ey, ez);
      jx += qmul(x1, atom_g[i]);
      jy += qmul(y1, atom_g[i]);
      r.kind = 1'b0;
      r.idx = 6'(i);
      r.x = 32'(heun_fix(atom_x[i], d0[i], ex, atom_nx[i]));
      r.y = 32'(heun_fix(atom_y[i], d1[i], ey, atom_ny[i]));
      r.z = 32'(heun_fix(atom_z[i], d2[i], ez, 0));
      r.q = '0;
      r.p = '0;
      r.ovf = dropped;
      r.last = 1'b0;
      pending_results = {pending_results, r};
    end
    dq2 = clamp32(-(jy >>> 1) - (qmul(k, q1) >>> 1));
    dp2 = clamp32((jx >>> 1) - (qmul(k, p1) >>> 1));
    r.kind = 1'b1;
    r.idx = '0;
    r.x = '0;
    r.y = '0;
    r.z = '0;
    r.q = 32'(heun_fix(q, dq, dq2, nq));
    r.p = 32'(heun_fix(p, dp, dp2, np));
    r.ovf = dropped;
    r.last = 1'b1;
    pending_results = {pending_results, r};
    n_atoms = 0;
    dropped = 1'b0;
  endtask

  // Sends one beat. Called at a rising edge and returns at the edge where the
  // beat was accepted, so back-to-back beats keep valid high throughout.
  task automatic send_beat(input beat_t b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.mode <= b.mode;
    in_if.spin_x <= b.sx;
    in_if.spin_y <= b.sy;
    in_if.spin_z <= b.sz;
    in_if.coupling <= b.g;
    in_if.noise_x <= b.nx;
    in_if.noise_y <= b.ny;
    in_if.field_q <= b.fq;
    in_if.field_p <= b.fp;
    in_if.noise_q <= b.nq;
    in_if.noise_p <= b.np;
    // Ready is stable mid-cycle; a high ready there means the next edge takes it.
    forever begin
      @(negedge clk);
      if (in_if.ready) break;
    end
    @(posedge clk);
    absorb_beat(b);
  endtask

  // Releases the input channel and waits until every queued beat has come out.
  // The trailing cycles cover the block finishing up after the field beat.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Writes one register; the strobe stays up so that writes can follow back
  // to back, and end_writes drops it after the last one.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= value;
    forever begin
      @(negedge clk);
      if (cfg_if.ready) break;
    end
    @(posedge clk);
    case (idx)
      CFG_TIME_STEP:    dt_q = value & 32'h1FFFF;
      CFG_CAVITY_DECAY: kappa_q = value & 32'h7FFFFFFF;
      CFG_DEPHASING:    deph_q = value & 32'h7FFFFFFF;
      default: ;
    endcase
  endtask

  task automatic end_writes();
    cfg_if.valid <= 1'b0;
  endtask

  // Operand mix: fully random words, small values near unity where the
  // dynamics stay in range, and the corner words of the format.
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFFFFFF;
          1: return 32'h80000000;
          2: return 32'h0;
          3: return 32'hFFFFFFFF;
          default: return 32'h00010000;
        endcase
      end
      default: return 32'($signed($urandom_range(0, 32'h3FFFF)) - 32'sh1FFFF);
    endcase
  endfunction

  function automatic beat_t random_atom();
    beat_t b;
    b.mode = 1'b0;
    b.sx = pick_value();
    b.sy = pick_value();
    b.sz = pick_value();
    b.g = pick_value();
    b.nx = pick_value();
    b.ny = pick_value();
    // Field words are ignored in this mode but still toggle.
    b.fq = $urandom;
    b.fp = $urandom;
    b.nq = $urandom;
    b.np = $urandom;
    return b;
  endfunction

  function automatic beat_t random_field();
    beat_t b;
    b = random_atom();
    b.mode = 1'b1;
    b.fq = pick_value();
    b.fp = pick_value();
    b.nq = pick_value();
    b.np = pick_value();
    return b;
  endfunction

  function automatic beat_t flat_atom(input logic [31:0] v);
    beat_t b;
    b = '{mode: 1'b0, sx: v, sy: v, sz: v, g: v, nx: v, ny: v,
          fq: ~v, fp: ~v, nq: ~v, np: ~v};
    return b;
  endfunction

  function automatic beat_t flat_field(input logic [31:0] v);
    beat_t b;
    b = flat_atom(~v);
    b.mode = 1'b1;
    b.fq = v;
    b.fp = v;
    b.nq = v;
    b.np = v;
    return b;
  endfunction

  // Sends a batch of random atoms closed by a random field beat.
  task automatic run_batch(input int atoms);
    for (int i = 0; i < atoms; i++) send_beat(random_atom());
    send_beat(random_field());
  endtask

  // Reset values, an empty batch and a small ordinary batch.
  task automatic test_reset_defaults();
    send_beat(random_field());
    run_batch(3);
    drain_results();
  endtask

  // Mostly extreme words, with decay and dephasing at their maximum, then every register at zero.
  task automatic test_extremes();
    write_reg(CFG_TIME_STEP, 32'd65536);
    write_reg(CFG_CAVITY_DECAY, 32'h7FFFFFFF);
    write_reg(CFG_DEPHASING, 32'h7FFFFFFF);
    end_writes();
    send_beat(flat_atom(32'h7FFFFFFF));
    send_beat(flat_atom(32'h80000000));
    send_beat(flat_atom(32'hFFFFFFFF));
    send_beat(flat_field(32'h7FFFFFFF));
    send_beat(flat_atom(32'h00010000));
    send_beat(flat_atom(32'h80000000));
    send_beat(flat_field(32'h80000000));
    drain_results();
    write_reg(CFG_TIME_STEP, 32'd0);
    write_reg(CFG_CAVITY_DECAY, 32'd0);
    write_reg(CFG_DEPHASING, 32'd0);
    end_writes();
    send_beat(flat_atom(32'h00020000));
    send_beat(flat_field(32'hFFFF0000));
    drain_results();
  endtask

  // A full store: extra atoms are dropped, every beat of that step carries the
  // overflow flag, and the next batch starts clean.
  task automatic test_overflow();
    write_reg(CFG_TIME_STEP, 32'd66);
    write_reg(CFG_CAVITY_DECAY, 32'd65536);
    write_reg(CFG_DEPHASING, 32'd1000);
    end_writes();
    run_batch(MAX_ATOMS + 3);
    run_batch(2);
    drain_results();
  endtask

  // The receiver holds off for a long stretch while batches keep coming, so
  // the output register fills and the input channel stalls.
  task automatic test_backpressure();
    hold_cycles = 600;
    run_batch(4);
    run_batch(3);
    run_batch(0);
    drain_results();
  endtask

  // Random batches over several register settings; mostly small batches, a
  // few near or past capacity, and stretches without any idling.
  task automatic test_random_batches();
    int items;
    int atoms;
    items = 0;
    for (int phase = 0; items < 130; phase++) begin
      write_reg(CFG_TIME_STEP, (phase % 3 == 0) ? 32'd65536 : $urandom_range(0, 65536));
      write_reg(CFG_CAVITY_DECAY, (phase % 4 == 0) ? 32'h7FFFFFFF : $urandom_range(0, 32'h40000));
      write_reg(CFG_DEPHASING, (phase % 4 == 1) ? 32'h7FFFFFFF : $urandom_range(0, 32'h20000));
      end_writes();
      quiet = (phase % 3 == 2);
      for (int b = 0; b < 4; b++) begin
        atoms = ($urandom_range(0, 11) == 0) ? $urandom_range(28, MAX_ATOMS + 3)
                                               : $urandom_range(0, 6);
        run_batch(atoms);
        items += atoms + 1;
      end
      drain_results();
      quiet = 1'b0;
    end
  endtask

  // Receiver: random stalls between beats, plus any long hold-off requested.
  initial begin
    int stall;
    stall = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (beat_taken) begin
        beat_taken = 1'b0;
        stall = quiet ? 0 : $urandom_range(0, 14);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Output monitor: mid-cycle both sides are stable, so a beat seen here with
  // ready high is the one the next edge accepts.
  initial begin
    result_t exp_r;
    forever begin
      @(negedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        beat_taken = 1'b1;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("Unexpected output beat: kind %0d index %0d", out_if.kind,
                     out_if.atom_index);
        end else begin
          exp_r = pending_results.pop_front();
          if (out_if.kind !== exp_r.kind || out_if.atom_index !== exp_r.idx ||
              out_if.new_spin_x !== exp_r.x || out_if.new_spin_y !== exp_r.y ||
              out_if.new_spin_z !== exp_r.z || out_if.new_field_q !== exp_r.q ||
              out_if.new_field_p !== exp_r.p || out_if.overflow !== exp_r.ovf ||
              out_if.last !== exp_r.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch: expected kind %0d idx %0d x %h y %h z %h q %h p %h ovf %0d last %0d",
                       exp_r.kind, exp_r.idx, exp_r.x, exp_r.y, exp_r.z, exp_r.q, exp_r.p,
                       exp_r.ovf, exp_r.last);
              $display("          actual   kind %0d idx %0d x %h y %h z %h q %h p %h ovf %0d last %0d",
                       out_if.kind, out_if.atom_index, out_if.new_spin_x, out_if.new_spin_y,
                       out_if.new_spin_z, out_if.new_field_q, out_if.new_field_p,
                       out_if.overflow, out_if.last);
            end
          end
        end
      end
    end
  end

  initial begin
    dt_q = 66;
    kappa_q = 65536;
    deph_q = 0;
    n_atoms = 0;
    dropped = 1'b0;
    mismatches = 0;
    quiet = 1'b0;
    hold_cycles = 0;
    beat_taken = 1'b0;
    in_if.valid <= 1'b0;
    in_if.mode <= 1'b0;
    in_if.spin_x <= '0;
    in_if.spin_y <= '0;
    in_if.spin_z <= '0;
    in_if.coupling <= '0;
    in_if.noise_x <= '0;
    in_if.noise_y <= '0;
    in_if.field_q <= '0;
    in_if.field_p <= '0;
    in_if.noise_q <= '0;
    in_if.noise_p <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= CFG_TIME_STEP;
    cfg_if.data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_overflow();
    test_backpressure();
    test_random_batches();

    drain_results();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #30ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
rtl/schsde_pkg.sv
rtl/schsde_if.sv
rtl/schsde_ram.sv
rtl/schsde_mul.sv
rtl/spin_cavity_heun_sde_step_core.sv
tb/spin_cavity_heun_sde_step_core_tb.sv
